[rtl/core/rrts_pkg.sv]
// Package for the round-robin task switcher.
// Holds the widths, command and status codes and memory control struct of the core.
// No dependencies.
package rrts_pkg;

    localparam int PTR_W = 32;
    localparam int TICK_W = 32;
    localparam int ID_W = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_NO_CURRENT = 2'd2
    } status_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [PTR_W-1:0] wdata;
    } mem_ctrl_t;

endpackage

[rtl/core/rrts_ptr_mem.sv]
// Saved stack pointer store for the round-robin task switcher.
// Simple dual-port synchronous memory with a registered read.
// Depends on rrts_pkg.
module rrts_ptr_mem
    import rrts_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  mem_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] raddr,
    output logic [PTR_W-1:0]  rdata
);

    logic [PTR_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[waddr] <= ctrl.wdata;
        end
    end

    // Read address can equal the write address in the same cycle (a lone task);
    // the controller then forwards the written pointer itself in that case.
    always_ff @(posedge aclk) begin
        if (ctrl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/round_robin_task_switcher.sv]
// Top level of the round-robin task switcher.
// Uses rrts_pkg and the saved pointer memory rrts_ptr_mem.
//
// Usage:
// The s_ channel takes one command per transaction: s_cmd selects a scheduler
// tick or the start of a new task, s_stack_ptr carries the pointer to save
// (tick) or the initial stack pointer (start). The m_ channel returns one
// result per command: the task id, the pointer to resume, a status code and
// the tick count after the command.
// Each command passes through two states: on acceptance in ST_IDLE the memory
// is written and the read of the next task's saved pointer is issued; ST_READ
// loads the result register once it is free, and m_valid rises with that load.
// s_ready is low in ST_READ, so no new command is taken until then.
// Slots are filled in order and never freed, so the running slots are always
// the prefix counted by the fill register; the next task is found by one
// increment and compare.
// Reset empties the task table and clears the tick counter at once; no
// clearing pass is needed. When m_ready is low the result waits in the output
// register; one more command is taken, then s_ready stays low until it has room.
module round_robin_task_switcher
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [PTR_W-1:0]  s_stack_ptr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_task_id,
    output logic [PTR_W-1:0]  m_load_ptr,
    output logic [1:0]        m_status,
    output logic [TICK_W-1:0] m_tick_count
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int WIDE_W = SLOT_W + ID_W;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    status_t             ctx_status_reg, ctx_status_next;
    logic [SLOT_W-1:0]   ctx_id_reg, ctx_id_next;
    logic [PTR_W-1:0]    ctx_ptr_reg, ctx_ptr_next;
    logic                ctx_use_mem_reg, ctx_use_mem_next;
    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     m_task_id_reg, m_task_id_next;
    logic [PTR_W-1:0]    m_load_ptr_reg, m_load_ptr_next;
    status_t             m_status_reg, m_status_next;
    logic [TICK_W-1:0]   m_tick_count_reg, m_tick_count_next;

    logic                s_accept;
    logic                out_free;
    logic [CNT_W-1:0]    cur_inc;
    logic [SLOT_W-1:0]   next_slot;
    logic                is_full;
    logic [SLOT_W-1:0]   free_slot;
    logic [WIDE_W-1:0]   id_wide;
    mem_ctrl_t           mem_ctrl;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [PTR_W-1:0]    mem_rdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Running slots occupy indexes below the fill count.
    assign cur_inc   = CNT_W'(cur_slot_reg) + CNT_W'(1);
    assign next_slot = (cur_inc < fill_reg) ? cur_inc[SLOT_W-1:0] : '0;
    assign is_full   = (fill_reg == CNT_W'(SLOT_COUNT));
    assign free_slot = fill_reg[SLOT_W-1:0];

    always_comb begin
        mem_ctrl.wdata = s_stack_ptr;
        mem_ctrl.we    = 1'b0;
        mem_ctrl.re    = 1'b0;
        mem_waddr      = free_slot;
        if (s_accept) begin
            if (s_cmd == CMD_TICK) begin
                mem_waddr   = cur_slot_reg;
                mem_ctrl.we = cur_valid_reg;
                mem_ctrl.re = cur_valid_reg;
            end else begin
                mem_ctrl.we = !is_full;
            end
        end
    end

    rrts_ptr_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_ptr_mem (
        .aclk  (aclk),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .raddr (next_slot),
        .rdata (mem_rdata)
    );

    assign id_wide = WIDE_W'(ctx_id_reg);

    always_comb begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        cur_slot_next     = cur_slot_reg;
        cur_valid_next    = cur_valid_reg;
        tick_next         = tick_reg;
        ctx_status_next   = ctx_status_reg;
        ctx_id_next       = ctx_id_reg;
        ctx_ptr_next      = ctx_ptr_reg;
        ctx_use_mem_next  = ctx_use_mem_reg;
        m_valid_next      = m_valid_reg;
        m_task_id_next    = m_task_id_reg;
        m_load_ptr_next   = m_load_ptr_reg;
        m_status_next     = m_status_reg;
        m_tick_count_next = m_tick_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next       = ST_READ;
                    ctx_use_mem_next = 1'b0;
                    if (s_cmd == CMD_TICK) begin
                        tick_next    = tick_reg + TICK_W'(1);
                        ctx_ptr_next = s_stack_ptr;
                        if (cur_valid_reg) begin
                            ctx_status_next  = STATUS_OK;
                            ctx_id_next      = next_slot;
                            // A lone task resumes with the pointer just saved.
                            ctx_use_mem_next = (next_slot != cur_slot_reg);
                            cur_slot_next    = next_slot;
                        end else begin
                            ctx_status_next = STATUS_NO_CURRENT;
                            ctx_id_next     = '0;
                        end
                    end else begin
                        ctx_ptr_next = '0;
                        if (is_full) begin
                            ctx_status_next = STATUS_FULL;
                            ctx_id_next     = '0;
                        end else begin
                            ctx_status_next = STATUS_OK;
                            ctx_id_next     = free_slot;
                            fill_next       = fill_reg + CNT_W'(1);
                            if (!cur_valid_reg) begin
                                cur_slot_next  = free_slot;
                                cur_valid_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next        = ST_IDLE;
                    m_valid_next      = 1'b1;
                    m_task_id_next    = id_wide[ID_W-1:0];
                    m_load_ptr_next   = ctx_use_mem_reg ? mem_rdata : ctx_ptr_reg;
                    m_status_next     = ctx_status_reg;
                    m_tick_count_next = tick_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            tick_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            tick_reg      <= tick_next;
            m_valid_reg   <= m_valid_next;
        end
        ctx_status_reg   <= ctx_status_next;
        ctx_id_reg       <= ctx_id_next;
        ctx_ptr_reg      <= ctx_ptr_next;
        ctx_use_mem_reg  <= ctx_use_mem_next;
        m_task_id_reg    <= m_task_id_next;
        m_load_ptr_reg   <= m_load_ptr_next;
        m_status_reg     <= m_status_next;
        m_tick_count_reg <= m_tick_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_task_id    = m_task_id_reg;
    assign m_load_ptr   = m_load_ptr_reg;
    assign m_status     = m_status_reg;
    assign m_tick_count = m_tick_count_reg;

endmodule

[tb/tb_round_robin_task_switcher.sv]
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_task_switcher.
// Depends on rrts_pkg and the switcher RTL; predicts every result internally
// and compares it with the m_ channel under random idling on both sides.
module tb_round_robin_task_switcher
    import rrts_pkg::*;
();

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [PTR_W-1:0]  load_ptr;
        status_t           status;
        logic [TICK_W-1:0] tick_count;
    } switch_result_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_cmd = CMD_TICK;
    logic [PTR_W-1:0]  s_stack_ptr = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ID_W-1:0]   m_task_id;
    logic [PTR_W-1:0]  m_load_ptr;
    logic [1:0]        m_status;
    logic [TICK_W-1:0] m_tick_count;

    // Shadow of the task table.
    logic              slot_busy [SLOTS];
    logic [PTR_W-1:0]  slot_sp [SLOTS];
    int                cur_slot;
    logic              cur_valid;
    logic [TICK_W-1:0] tick_total;
    int                tasks_started;

    switch_result_t    expected_results [$];
    switch_result_t    oldest_result;
    int                mismatches = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                stall_request = 0;
    int                cycle_count = 0;

    round_robin_task_switcher #(.SLOT_COUNT(SLOTS)) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_stack_ptr  (s_stack_ptr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_task_id    (m_task_id),
        .m_load_ptr   (m_load_ptr),
        .m_status     (m_status),
        .m_tick_count (m_tick_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Applies one command to the shadow table and returns the result it causes.
    function automatic switch_result_t predict_switch(input logic cmd,
                                                      input logic [PTR_W-1:0] sp);
        switch_result_t r;
        int idx;
        int pick;
        r.task_id = '0;
        r.load_ptr = '0;
        r.status = STATUS_OK;
        pick = -1;
        if (cmd == CMD_TICK) begin
            tick_total = tick_total + 1'b1;
            if (!cur_valid) begin
                r.load_ptr = sp;
                r.status = STATUS_NO_CURRENT;
            end else begin
                slot_sp[cur_slot] = sp;
                // The current slot is the last one searched.
                for (int off = 1; off <= SLOTS; off++) begin
                    idx = (cur_slot + off) % SLOTS;
                    if (pick < 0 && slot_busy[idx]) pick = idx;
                end
                if (pick >= 0) cur_slot = pick;
                r.task_id = cur_slot[ID_W-1:0];
                r.load_ptr = slot_sp[cur_slot];
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (pick < 0 && !slot_busy[i]) pick = i;
            end
            if (pick < 0) begin
                r.status = STATUS_FULL;
            end else begin
                slot_busy[pick] = 1'b1;
                slot_sp[pick] = sp;
                if (!cur_valid) begin
                    cur_slot = pick;
                    cur_valid = 1'b1;
                end
                tasks_started++;
                r.task_id = pick[ID_W-1:0];
            end
        end
        r.tick_count = tick_total;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] rand_ptr();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one command and returns at the edge where it is accepted.
    // Valid stays high on return so back-to-back commands need no extra write.
    task automatic send_command(input logic cmd, input logic [PTR_W-1:0] sp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_stack_ptr <= sp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_switch(cmd, sp));
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_request > 0) begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with none pending: task_id %0d load_ptr %h status %0d",
                       m_task_id, m_load_ptr, m_status);
                mismatches++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_task_id !== oldest_result.task_id) begin
                    $error("task_id: expected %0d, got %0d",
                           oldest_result.task_id, m_task_id);
                    mismatches++;
                end
                if (m_load_ptr !== oldest_result.load_ptr) begin
                    $error("load_ptr: expected %h, got %h",
                           oldest_result.load_ptr, m_load_ptr);
                    mismatches++;
                end
                if (m_status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, m_status);
                    mismatches++;
                end
                if (m_tick_count !== oldest_result.tick_count) begin
                    $error("tick_count: expected %0d, got %0d",
                           oldest_result.tick_count, m_tick_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_tick_without_task();
        send_command(CMD_TICK, 32'h0000_0000);
        send_command(CMD_TICK, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'h5555_5555);
    endtask

    // A lone task keeps being picked; then two and three tasks alternate.
    task automatic test_first_tasks();
        send_command(CMD_START, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'h0000_0000);
        send_command(CMD_TICK, 32'h1234_5678);
        send_command(CMD_START, 32'h0000_0000);
        send_command(CMD_TICK, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 32'hDEAD_BEEF);
        send_command(CMD_TICK, 32'hAAAA_AAAA);
        send_command(CMD_START, 32'hA5A5_A5A5);
        send_command(CMD_TICK, 32'h5A5A_5A5A);
        send_command(CMD_TICK, 32'h0F0F_F0F0);
        send_command(CMD_TICK, 32'h8000_0001);
    endtask

    // Mostly ticks while the table fills slowly, leaving one slot free.
    task automatic test_random_partial_table(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 29) == 0 && tasks_started < SLOTS - 1)
                send_command(CMD_START, rand_ptr());
            else
                send_command(CMD_TICK, rand_ptr());
        end
    endtask

    // The receiver stops for a long stretch while the sender keeps offering,
    // so the output register fills and s_ready must drop.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_request = 80;
        for (int n = 0; n < 24; n++)
            send_command(($urandom_range(0, 3) == 0) ? CMD_START : CMD_TICK, rand_ptr());
    endtask

    task automatic test_table_full();
        while (tasks_started < SLOTS)
            send_command(CMD_START, rand_ptr());
        send_command(CMD_START, 32'hFFFF_FFFF);
        send_command(CMD_TICK, rand_ptr());
        send_command(CMD_START, 32'h0000_0000);
        send_command(CMD_START, rand_ptr());
    endtask

    task automatic test_random_full_table(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_command(CMD_START, rand_ptr());
            else
                send_command(CMD_TICK, rand_ptr());
        end
    endtask

    initial begin : main
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_sp[i] = '0;
        end
        cur_slot = 0;
        cur_valid = 1'b0;
        tick_total = '0;
        tasks_started = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 70;
        test_tick_without_task();
        test_first_tasks();
        test_random_partial_table(500);
        test_output_backpressure();

        send_idle_pct = 70;
        recv_idle_pct = 30;
        test_table_full();
        test_random_full_table(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_full_table(380);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/rrts_pkg.sv
rtl/core/rrts_ptr_mem.sv
rtl/core/round_robin_task_switcher.sv
tb/tb_round_robin_task_switcher.sv
